>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the core top. Define ASSERT_OFF to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
`else
`define CHK_IMPLY(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared widths, method codes and lane result type for the point boundary
// constrain core.
// ----------------------------------------------------------------------------
package pbc_pkg;

	localparam int CW       = 16;      // coordinate width
	localparam int DW       = CW + 2;  // divisor width (mirror period up to 2^(CW+1))
	localparam int LANE_LAT = CW + 2;  // input register, CW divide stages, post stage

	typedef enum logic [1:0] {
		BM_PASS   = 2'd0,
		BM_MIRROR = 2'd1,
		BM_CLAMP  = 2'd2,
		BM_WRAP   = 2'd3
	} method_t;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t fixed;    // axis after the method was applied
		coord_t orig;     // axis as it came in
		logic   out_rng;  // axis was outside its bounds
		logic   bad;      // out of range with lower above upper
	} lane_res_t;

endpackage

>>> rtl/core/pbc_divider.sv
// ----------------------------------------------------------------------------
// pbc_divider
// Pipelined restoring remainder unit: one quotient bit per stage, CW stages,
// a new dividend/divisor pair may enter every cycle.
// ----------------------------------------------------------------------------
module pbc_divider (
	input  logic                     clk,
	input  logic [pbc_pkg::CW-1:0]   dividend,
	input  logic [pbc_pkg::DW-1:0]   divisor,
	output logic [pbc_pkg::DW-2:0]   remainder
);
	import pbc_pkg::*;

	logic [CW-1:0] dvd_q [CW-1];
	logic [DW-1:0] dvs_q [CW-1];
	logic [DW-2:0] rem_q [CW];

	for (genvar i = 0; i < CW; i++) begin : g_stage
		logic [CW-1:0] dvd_cur;
		logic [DW-1:0] dvs_cur;
		logic [DW-2:0] rem_cur;
		logic [DW-1:0] trial;
		logic [DW-1:0] diff;

		if (i == 0) begin : g_first
			assign dvd_cur = dividend;
			assign dvs_cur = divisor;
			assign rem_cur = '0;
		end else begin : g_next
			assign dvd_cur = dvd_q[i-1];
			assign dvs_cur = dvs_q[i-1];
			assign rem_cur = rem_q[i-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {rem_cur, dvd_cur[CW-1]};
		assign diff  = trial - dvs_cur;

		always_ff @(posedge clk) begin
			rem_q[i] <= (trial >= dvs_cur) ? diff[DW-2:0] : trial[DW-2:0];
		end

		if (i < CW - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				dvd_q[i] <= {dvd_cur[CW-2:0], 1'b0};
				dvs_q[i] <= dvs_cur;
			end
		end
	end

	assign remainder = rem_q[CW-1];

endmodule

>>> rtl/core/pbc_lane.sv
// ----------------------------------------------------------------------------
// pbc_lane
// One axis: range check, remainder by the period through the pipelined
// divider, then mirror fold, clamp or wrap and the bound offset.
// ----------------------------------------------------------------------------
module pbc_lane (
	input  logic                clk,
	input  pbc_pkg::method_t    method,
	input  pbc_pkg::coord_t     p,
	input  pbc_pkg::coord_t     lo,
	input  pbc_pkg::coord_t     hi,
	output pbc_pkg::lane_res_t  res
);
	import pbc_pkg::*;

	typedef struct packed {
		coord_t  p;
		coord_t  lo;
		coord_t  clamp_v;
		logic [CW:0] m;     // period size+1
		logic    neg;       // p below lower
		logic    out_rng;
		logic    bad;
		method_t method;
	} side_t;

	logic signed [CW:0] d;
	logic signed [CW:0] size;
	logic               below;
	logic               above;
	logic [CW:0]        m;
	logic [CW-1:0]      mag;

	always_comb begin
		d     = {p[CW-1], p} - {lo[CW-1], lo};
		size  = {hi[CW-1], hi} - {lo[CW-1], lo};
		below = p < lo;
		above = p > hi;
		m     = {1'b0, size[CW-1:0]} + (CW+1)'(1);
		mag   = d[CW] ? CW'(-d) : d[CW-1:0];
	end

	side_t         side_s1;
	logic [CW-1:0] mag_s1;
	logic [DW-1:0] dvs_s1;

	always_ff @(posedge clk) begin
		side_s1.p       <= p;
		side_s1.lo      <= lo;
		side_s1.clamp_v <= below ? lo : hi;
		side_s1.m       <= m;
		side_s1.neg     <= d[CW];
		side_s1.out_rng <= below | above;
		side_s1.bad     <= (below | above) && (lo > hi);
		side_s1.method  <= method;
		mag_s1          <= mag;
		// mirror folds over twice the period
		dvs_s1          <= (method == BM_MIRROR) ? {m, 1'b0} : {1'b0, m};
	end

	// carry the side data alongside the divide stages
	side_t side_q [CW];

	for (genvar i = 0; i < CW; i++) begin : g_side
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				side_q[i] <= side_s1;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	logic [DW-2:0] rem;

	pbc_divider u_div (
		.clk       (clk),
		.dividend  (mag_s1),
		.divisor   (dvs_s1),
		.remainder (rem)
	);

	side_t       sd;
	logic [CW:0] wv;
	logic [CW:0] mv0;
	logic [CW:0] mv;
	logic [CW+1:0] twom1;
	coord_t      fixed;

	always_comb begin
		sd    = side_q[CW-1];
		// negative side: truncating remainder, then m - rem (wrap) or rem - 1 (mirror)
		wv    = (sd.neg && rem != '0) ? sd.m - rem : rem;
		mv0   = (sd.neg && rem != '0) ? rem - (CW+1)'(1) : rem;
		twom1 = {sd.m, 1'b0} - (CW+2)'(1);
		mv    = (mv0 >= sd.m) ? (CW+1)'(twom1 - {1'b0, mv0}) : mv0;
		case (sd.method)
			BM_MIRROR: fixed = sd.lo + $signed(mv[CW-1:0]);
			BM_CLAMP:  fixed = sd.clamp_v;
			BM_WRAP:   fixed = sd.lo + $signed(wv[CW-1:0]);
			default:   fixed = sd.p;
		endcase
		if (!sd.out_rng) begin
			fixed = sd.p;
		end
	end

	lane_res_t res_s2;

	always_ff @(posedge clk) begin
		res_s2.fixed   <= fixed;
		res_s2.orig    <= sd.p;
		res_s2.out_rng <= sd.out_rng;
		res_s2.bad     <= sd.bad;
	end

	assign res = res_s2;

endmodule

>>> rtl/core/pbc_merge.sv
// ----------------------------------------------------------------------------
// pbc_merge
// Combines the two axis lanes: any bad lane returns the point untouched,
// and the flags are gathered into the registered result.
// ----------------------------------------------------------------------------
module pbc_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pbc_pkg::lane_res_t  res_x,
	input  pbc_pkg::lane_res_t  res_y,
	output logic                done,
	output pbc_pkg::coord_t     out_x,
	output pbc_pkg::coord_t     out_y,
	output logic                point_moved,
	output logic                bound_error
);
	import pbc_pkg::*;

	logic   err;
	logic   done_q;
	coord_t out_x_q;
	coord_t out_y_q;
	logic   moved_q;
	logic   err_q;

	assign err = res_x.bad | res_y.bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			out_x_q <= err ? res_x.orig : res_x.fixed;
			out_y_q <= err ? res_y.orig : res_y.fixed;
			moved_q <= res_x.out_rng | res_y.out_rng;
			err_q   <= err;
		end
	end

	assign done        = done_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign point_moved = moved_q;
	assign bound_error = err_q;

endmodule

>>> rtl/core/point_boundary_constrain_top.sv
// ----------------------------------------------------------------------------
// point_boundary_constrain_top
// Path: a beat accepted on start passes the lane input register, the CW remainder
//   stages, the lane post stage and the merge register, then shows done high.
// Throughput: one beat per cycle; busy stays low, the x and y lanes each run a
//   CW-stage remainder pipeline and the receiver cannot stall.
// Reset: arst_n clears the method register (pass), the valid pipeline and done.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_boundary_constrain_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  pbc_pkg::coord_t   point_x,
	input  pbc_pkg::coord_t   point_y,
	input  pbc_pkg::coord_t   lower_x,
	input  pbc_pkg::coord_t   upper_x,
	input  pbc_pkg::coord_t   lower_y,
	input  pbc_pkg::coord_t   upper_y,
	output logic              done,
	output pbc_pkg::coord_t   out_x,
	output pbc_pkg::coord_t   out_y,
	output logic              point_moved,
	output logic              bound_error
);
	import pbc_pkg::*;

	method_t              method_q;
	logic                 accept;
	logic [LANE_LAT-1:0]  vld_q;
	lane_res_t            res_x;
	lane_res_t            res_y;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= BM_PASS;
			vld_q    <= '0;
		end else begin
			if (cfg_we) begin
				method_q <= method_t'(cfg_wdata);
			end
			// advance the beat marker with the lane pipelines
			vld_q <= {vld_q[LANE_LAT-2:0], accept};
		end
	end

	pbc_lane u_lane_x (
		.clk    (clk),
		.method (method_q),
		.p      (point_x),
		.lo     (lower_x),
		.hi     (upper_x),
		.res    (res_x)
	);

	pbc_lane u_lane_y (
		.clk    (clk),
		.method (method_q),
		.p      (point_y),
		.lo     (lower_y),
		.hi     (upper_y),
		.res    (res_y)
	);

	pbc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_q[LANE_LAT-1]),
		.res_x       (res_x),
		.res_y       (res_y),
		.done        (done),
		.out_x       (out_x),
		.out_y       (out_y),
		.point_moved (point_moved),
		.bound_error (bound_error)
	);

	`CHK_IMPLY(a_err_implies_moved, clk, arst_n, done && bound_error, point_moved)
	`CHK_IMPLY(a_x_inrange_kept, clk, arst_n, vld_q[LANE_LAT-1] && !res_x.out_rng, res_x.fixed == res_x.orig)
	`CHK_IMPLY(a_y_bad_is_out, clk, arst_n, vld_q[LANE_LAT-1] && res_y.bad, res_y.out_rng)
	`CHK_NEXT(a_lane_beat_done, clk, arst_n, vld_q[LANE_LAT-1], done)

endmodule
